// ===== rtl/core/cpid_pkg.sv =====
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared constants and register codes for the clamped PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;
    localparam int ILIM_W    = 31;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_SETPOINT  = 3'd3,
        REG_OUT_UPPER = 3'd4,
        REG_OUT_LOWER = 3'd5,
        REG_INT_LIMIT = 3'd6
    } cfg_index_t;

    localparam logic signed [DATA_W-1:0] OUT_UPPER_RESET = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_LOWER_RESET = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== rtl/core/clamped_pid_controller.sv =====
// ----------------------------------------------------------------------------
// clamped_pid_controller
// Incremental PID with clamped integral and clamped, accumulating output.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------
//   s_       | in        | tdata: measured_value
//   m_       | out       | tdata: drive_value, tuser: output_clamped
//   cfg_     | in        | write-only register port, index 0..6
//
// One item per cycle sustained while m_tready does not stall the output.
// Stages: error/integral, three multiplies, product sum, output accumulate
// and clamp. The running-output add and clamp in the last stage sets fmax.
// Each stage holds its item on stall; empty stages keep filling, so input
// is taken while a result waits on m_tready.
// Reset clears valids, gains, setpoint, int_limit, state; out limits full range.
// ----------------------------------------------------------------------------
module clamped_pid_controller (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cpid_pkg::DATA_W-1:0]         s_tdata,   // [31:0] measured_value

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cpid_pkg::DATA_W-1:0]         m_tdata,   // [31:0] drive_value
    output logic                                m_tuser,   // [0] output_clamped

    input  logic                                cfg_wr_en,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpid_pkg::DATA_W-1:0]         cfg_wdata
);

    localparam int DW = cpid_pkg::DATA_W;
    localparam int TW = cpid_pkg::TERM_W;
    localparam int SW = cpid_pkg::SUM_W;
    localparam int PW = cpid_pkg::PROD_W;
    localparam int LW = cpid_pkg::ILIM_W;

    function automatic logic signed [DW-1:0] sat_w(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1]) begin
            return $signed({v[DW], {(DW-1){~v[DW]}}});
        end
        return $signed(v[DW-1:0]);
    endfunction

    // configuration
    logic signed [DW-1:0] kp_reg, ki_reg, kd_reg, setpoint_reg;
    logic signed [DW-1:0] upper_reg, lower_reg;
    logic        [LW-1:0] int_limit_reg;

    // state
    logic signed [DW-1:0] prev_err_reg, int_sum_reg, running_reg;

    // pipeline
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic signed [DW-1:0] meas_reg;
    logic signed [DW-1:0] err_reg, chg_reg, integ_reg;
    logic signed [TW-1:0] p_reg, i_reg, d_reg;
    logic signed [SW-1:0] psum_reg;
    logic        [DW-1:0] drive_reg;
    logic                 clamp_reg;

    logic rdy0, rdy1, rdy2, rdy3, out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign rdy3     = !v3_reg || out_free;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;

    assign s_tready = rdy0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = clamp_reg;

    wire adv0 = v0_reg && rdy1;
    wire adv1 = v1_reg && rdy2;
    wire adv2 = v2_reg && rdy3;
    wire adv3 = v3_reg && out_free;

    // stage 1: error, change, integral
    logic signed [DW:0]   err_wide, chg_wide, integ_wide, lim_pos, lim_neg;
    logic signed [DW-1:0] err_next, chg_next, integ_next;

    always_comb begin
        err_wide   = $signed({setpoint_reg[DW-1], setpoint_reg})
                   - $signed({meas_reg[DW-1], meas_reg});
        err_next   = sat_w(err_wide);
        chg_wide   = $signed({err_next[DW-1], err_next})
                   - $signed({prev_err_reg[DW-1], prev_err_reg});
        chg_next   = sat_w(chg_wide);
        integ_wide = $signed({int_sum_reg[DW-1], int_sum_reg})
                   + $signed({err_next[DW-1], err_next});
        lim_pos    = $signed({{(DW+1-LW){1'b0}}, int_limit_reg});
        lim_neg    = -lim_pos;
        if (integ_wide > lim_pos) begin
            integ_next = lim_pos[DW-1:0];
        end else if (integ_wide < lim_neg) begin
            integ_next = lim_neg[DW-1:0];
        end else begin
            integ_next = integ_wide[DW-1:0];
        end
    end

    // stage 2: products, floor-shifted by dropping fraction bits
    logic signed [PW-1:0] p_full, i_full, d_full;

    always_comb begin
        p_full = PW'(err_reg) * PW'(kp_reg);
        i_full = PW'(integ_reg) * PW'(ki_reg);
        d_full = PW'(chg_reg) * PW'(kd_reg);
    end

    // stage 3: product sum
    logic signed [SW-1:0] psum_next;

    assign psum_next = $signed({{2{p_reg[TW-1]}}, p_reg})
                     + $signed({{2{i_reg[TW-1]}}, i_reg})
                     + $signed({{2{d_reg[TW-1]}}, d_reg});

    // stage 4: accumulate and clamp, upper limit first
    logic signed [SW-1:0] total, upper_ext, lower_ext;
    logic signed [DW-1:0] running_next;
    logic                 clamp_next;

    always_comb begin
        total     = psum_reg + $signed({{(SW-DW){running_reg[DW-1]}}, running_reg});
        upper_ext = $signed({{(SW-DW){upper_reg[DW-1]}}, upper_reg});
        lower_ext = $signed({{(SW-DW){lower_reg[DW-1]}}, lower_reg});
        if (total > upper_ext) begin
            running_next = upper_reg;
            clamp_next   = 1'b1;
        end else if (total < lower_ext) begin
            running_next = lower_reg;
            clamp_next   = 1'b1;
        end else begin
            running_next = total[DW-1:0];
            clamp_next   = 1'b0;
        end
    end

    // control, configuration and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            setpoint_reg  <= '0;
            upper_reg     <= cpid_pkg::OUT_UPPER_RESET;
            lower_reg     <= cpid_pkg::OUT_LOWER_RESET;
            int_limit_reg <= '0;
            prev_err_reg  <= '0;
            int_sum_reg   <= '0;
            running_reg   <= '0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (out_free) out_valid_reg <= v3_reg;

            if (adv0) begin
                prev_err_reg <= err_next;
                int_sum_reg  <= integ_next;
            end
            if (adv3) begin
                running_reg <= running_next;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    cpid_pkg::REG_KP:        kp_reg        <= cfg_wdata;
                    cpid_pkg::REG_KI:        ki_reg        <= cfg_wdata;
                    cpid_pkg::REG_KD:        kd_reg        <= cfg_wdata;
                    cpid_pkg::REG_SETPOINT:  setpoint_reg  <= cfg_wdata;
                    cpid_pkg::REG_OUT_UPPER: upper_reg     <= cfg_wdata;
                    cpid_pkg::REG_OUT_LOWER: lower_reg     <= cfg_wdata;
                    cpid_pkg::REG_INT_LIMIT: int_limit_reg <= cfg_wdata[LW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy0) begin
            meas_reg <= s_tdata;
        end
        if (adv0) begin
            err_reg   <= err_next;
            chg_reg   <= chg_next;
            integ_reg <= integ_next;
        end
        if (adv1) begin
            p_reg <= p_full[PW-1:cpid_pkg::FRAC_BITS];
            i_reg <= i_full[PW-1:cpid_pkg::FRAC_BITS];
            d_reg <= d_full[PW-1:cpid_pkg::FRAC_BITS];
        end
        if (adv2) begin
            psum_reg <= psum_next;
        end
        if (adv3) begin
            drive_reg <= running_next;
            clamp_reg <= clamp_next;
        end
    end

endmodule

// ===== rtl/core/cpid_checker.sv =====
// ----------------------------------------------------------------------------
// cpid_checker
// Port-level checks for the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module cpid_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cpid_pkg::DATA_W-1:0]     m_tdata,
    input logic                            m_tuser,
    input logic                            cfg_wr_en,
    input logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [cpid_pkg::DATA_W-1:0]     cfg_wdata
);

    logic signed [cpid_pkg::DATA_W-1:0] upper_reg, lower_reg;
    logic [2:0]                         inflight_reg;

    wire in_acc  = s_tvalid && s_tready;
    wire out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg    <= cpid_pkg::OUT_UPPER_RESET;
            lower_reg    <= cpid_pkg::OUT_LOWER_RESET;
            inflight_reg <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == cpid_pkg::REG_OUT_UPPER) upper_reg <= cfg_wdata;
            if (cfg_wr_en && cfg_index == cpid_pkg::REG_OUT_LOWER) lower_reg <= cfg_wdata;
            inflight_reg <= inflight_reg + {2'b00, in_acc} - {2'b00, out_acc};
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_clamped_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == upper_reg || m_tdata == lower_reg)
        else $error("clamped result is not a limit");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            $signed(m_tdata) <= upper_reg && $signed(m_tdata) >= lower_reg)
        else $error("unclamped result outside limits");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0 && inflight_reg <= 3'd5)
        else $error("result without matching item");

endmodule

bind clamped_pid_controller cpid_checker u_cpid_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);
